// ----- rtl/sdspi_pkg.sv -----
`timescale 1ns / 1ps
package sdspi_pkg;
  localparam int BLOCK_BYTES = 512;
  localparam int INIT_CLOCK_BYTES = 80;

  localparam logic [1:0] REQ_XCHG  = 2'd0;
  localparam logic [1:0] REQ_INIT  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_TOKEN  = 4'd1;
  localparam logic [3:0] ST_NOT_READY = 4'd2;
  localparam logic [3:0] ST_NO_CARD   = 4'd3;
  localparam logic [3:0] ST_UNUSABLE  = 4'd4;
  localparam logic [3:0] ST_ECHO      = 4'd5;
  localparam logic [3:0] ST_VOLTAGE   = 4'd6;
  localparam logic [3:0] ST_R1_ERR    = 4'd7;
  localparam logic [3:0] ST_CRC_REJ   = 4'd8;
  localparam logic [3:0] ST_WR_REJ    = 4'd9;
  localparam logic [3:0] ST_OTHER     = 4'd10;
  localparam logic [3:0] ST_BUSY      = 4'd11;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] block_address;
    logic [7:0]  write_byte;
    logic [7:0]  card_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select_low;
    logic       fast_clock;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       want_write_byte;
    logic       done_res;
    logic [3:0] status;
    logic [7:0] r1_value;
  } res_t;
endpackage

// ----- rtl/sd_card_spi_host_sequencer.sv -----
`timescale 1ns / 1ps
// SD card SPI-mode host sequencer. Every request (a start of init, block read
// or block write, or the card byte of the last transfer) yields exactly one
// result naming the next byte to shift out, chip select, clock speed and, at
// the end of an operation, a status. A two-entry request queue feeds a
// sequencer that handles one request per cycle, unless its one-entry result
// register is full and not popped. A request is held in the queue, then in
// the result register; the queue takes a new one every cycle while not full;
// in use one per SPI byte. timeout_limit (0 acts as 1) bounds every poll loop.
module sd_card_spi_host_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [31:0] block_address,
  input  logic [7:0]  write_byte,
  input  logic [7:0]  card_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte,
  output logic        tx_valid,
  output logic        chip_select_low,
  output logic        fast_clock,
  output logic [7:0]  read_byte,
  output logic        read_valid,
  output logic        want_write_byte,
  output logic        done_res,
  output logic [3:0]  status,
  output logic [7:0]  r1_value,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  sdspi_pkg::req_t in_req, q_req;
  sdspi_pkg::res_t res;
  logic q_valid, q_take;

  assign in_req = '{req_type: req_type, block_address: block_address,
                    write_byte: write_byte, card_byte: card_byte};

  sdspi_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_req(in_req),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take)
  );

  sdspi_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_req(q_req), .q_take(q_take),
    .empty(empty), .pop(pop), .res(res)
  );

  assign tx_byte         = res.tx_byte;
  assign tx_valid        = res.tx_valid;
  assign chip_select_low = res.chip_select_low;
  assign fast_clock      = res.fast_clock;
  assign read_byte       = res.read_byte;
  assign read_valid      = res.read_valid;
  assign want_write_byte = res.want_write_byte;
  assign done_res        = res.done_res;
  assign status          = res.status;
  assign r1_value        = res.r1_value;
endmodule

// ----- rtl/sdspi_front.sv -----
`timescale 1ns / 1ps
// input queue: accepts requests and presents them in order to the sequencer
module sdspi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sdspi_pkg::req_t   in_req,
  output logic              q_valid,
  output sdspi_pkg::req_t   q_req,
  input  logic              q_take
);
  localparam int AW = $clog2(sdspi_pkg::QDEPTH);
  sdspi_pkg::req_t slots [sdspi_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic do_push, do_pop;

  assign full    = (count == AW'(0) + (AW+1)'(sdspi_pkg::QDEPTH));
  assign q_valid = (count != '0);
  assign q_req   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= in_req;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ----- rtl/sdspi_back.sv -----
`timescale 1ns / 1ps
// sequencer: one request a cycle, stalled while its result waits
module sdspi_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              q_valid,
  input  sdspi_pkg::req_t   q_req,
  output logic              q_take,
  output logic              empty,
  input  logic              pop,
  output sdspi_pkg::res_t   res
);
  localparam logic [4:0] PH_IDLE = 5'd0, PH_CLOCK = 5'd1, PH_CMD0 = 5'd2,
    PH_CMD8 = 5'd3, PH_CMD1 = 5'd4, PH_OCR1 = 5'd5, PH_CRCON = 5'd6,
    PH_CMD55 = 5'd7, PH_ACMD41 = 5'd8, PH_CRCOFF = 5'd9, PH_BLEN = 5'd10,
    PH_OCR2 = 5'd11, PH_RDCMD = 5'd12, PH_RDTOK = 5'd13, PH_RDDATA = 5'd14,
    PH_RDCRC = 5'd15, PH_WRCMD = 5'd16, PH_WRDATA = 5'd17, PH_WRTAIL = 5'd18,
    PH_WRREADY = 5'd19;
  localparam logic [2:0] SUB_NONE = 3'd0, SUB_READY = 3'd1, SUB_CMD = 3'd2,
    SUB_R1 = 3'd3, SUB_R32 = 3'd4;
  localparam int BCW = $clog2(sdspi_pkg::BLOCK_BYTES + 1);

  logic [15:0]    timeout_limit;
  logic [4:0]     phase, phase_next;
  logic [2:0]     activity, activity_next;
  logic [15:0]    retry_count, retry_count_next;
  logic [15:0]    loop_count, loop_count_next;
  logic [BCW-1:0] byte_count, byte_count_next;
  logic [31:0]    card_address, card_address_next;
  logic [1:0]     capacity_status, capacity_status_next;
  logic [31:0]    response_word, response_word_next;
  logic           initialized, initialized_next;
  logic           cs_on, cs_on_next;

  sdspi_pkg::res_t out_reg, o;
  logic            out_full;
  logic [15:0]     lim;
  logic [7:0]      b;
  logic [15:0]     retry_inc, loop_inc;
  logic [BCW-1:0]  bc_inc;
  logic [31:0]     rw_shift;
  logic            step;

  assign lim       = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
  assign b         = q_req.card_byte;
  assign retry_inc = retry_count + 16'd1;
  assign loop_inc  = loop_count + 16'd1;
  assign bc_inc    = byte_count + BCW'(1);
  assign rw_shift  = {response_word[23:0], b};
  assign step      = q_valid && (!out_full || pop);
  assign q_take    = step;
  assign empty     = !out_full;
  assign res       = out_reg;

  // command frame byte for a phase
  function automatic logic [7:0] cmd_byte(input logic [4:0] ph,
                                          input logic [31:0] caddr,
                                          input logic [BCW-1:0] k);
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [6:0]  crc;
    idx = 6'd0; arg = 32'd0; crc = 7'h7F;
    unique case (ph)
      PH_CMD0:   begin idx = 6'd0;  crc = 7'h4A; end
      PH_CMD8:   begin idx = 6'd8;  arg = 32'h0000_01AA; crc = 7'h43; end
      PH_CMD1:   begin idx = 6'd1;  crc = 7'h7C; end
      PH_OCR1, PH_OCR2: begin idx = 6'd58; crc = 7'h7E; end
      PH_CRCON:  begin idx = 6'd59; arg = 32'd1; crc = 7'h41; end
      PH_CMD55:  begin idx = 6'd55; crc = 7'h32; end
      PH_ACMD41: begin idx = 6'd41; arg = 32'h4000_0000; crc = 7'h3B; end
      PH_CRCOFF: begin idx = 6'd59; crc = 7'h48; end
      PH_BLEN:   begin idx = 6'd16; arg = 32'h0000_0200; crc = 7'h0A; end
      PH_RDCMD:  begin idx = 6'd17; arg = caddr; end
      PH_WRCMD:  begin idx = 6'd24; arg = caddr; end
      default:   ;
    endcase
    case (k)
      BCW'(0): cmd_byte = {2'b01, idx};
      BCW'(1): cmd_byte = arg[31:24];
      BCW'(2): cmd_byte = arg[23:16];
      BCW'(3): cmd_byte = arg[15:8];
      BCW'(4): cmd_byte = arg[7:0];
      default: cmd_byte = {crc, 1'b1};
    endcase
  endfunction

  // next state and result of the request at the head of the queue
  always_comb begin
    logic       fin;
    logic [3:0] fst;
    logic [7:0] fr1;
    logic [4:0] bph;
    logic       bcmd, bready;
    logic [7:0] tx;
    logic       txv;
    fin = 1'b0; fst = sdspi_pkg::ST_OK; fr1 = 8'd0;
    bcmd = 1'b0; bready = 1'b0; bph = PH_IDLE;
    tx = 8'd0; txv = 1'b0;
    phase_next = phase; activity_next = activity;
    retry_count_next = retry_count; loop_count_next = loop_count;
    byte_count_next = byte_count; card_address_next = card_address;
    capacity_status_next = capacity_status; response_word_next = response_word;
    initialized_next = initialized; cs_on_next = cs_on;
    o = '0;

    if (q_req.req_type != sdspi_pkg::REQ_XCHG) begin
      if (phase != PH_IDLE) begin
        o.status = sdspi_pkg::ST_BUSY;
      end else if (q_req.req_type == sdspi_pkg::REQ_INIT) begin
        initialized_next = 1'b0; cs_on_next = 1'b0; phase_next = PH_CLOCK;
        activity_next = SUB_NONE; byte_count_next = '0; tx = 8'hFF; txv = 1'b1;
      end else begin
        card_address_next = (capacity_status == 2'd2) ?
          {q_req.block_address[22:0], 9'd0} : q_req.block_address;
        cs_on_next = 1'b1;
        bready = 1'b1;
        bph = (q_req.req_type == sdspi_pkg::REQ_READ) ? PH_RDCMD : PH_WRCMD;
      end
    end else if (phase != PH_IDLE) begin
      if (activity != SUB_NONE) begin
        case (activity)
          SUB_READY: begin
            if (b == 8'hFF) begin
              if (phase == PH_WRREADY) begin
                fin = 1'b1;
                case (response_word[2:0])
                  3'd2: fst = sdspi_pkg::ST_OK;
                  3'd5: fst = sdspi_pkg::ST_CRC_REJ;
                  3'd6: fst = sdspi_pkg::ST_WR_REJ;
                  default: fst = sdspi_pkg::ST_OTHER;
                endcase
              end else begin
                activity_next = SUB_CMD; byte_count_next = '0;
                tx = cmd_byte(phase, card_address, '0); txv = 1'b1;
              end
            end else begin
              retry_count_next = retry_inc;
              if (retry_inc >= lim) begin fin = 1'b1; fst = sdspi_pkg::ST_NOT_READY; end
              else begin tx = 8'hFF; txv = 1'b1; end
            end
          end
          SUB_CMD: begin
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(6)) begin
              tx = cmd_byte(phase, card_address, bc_inc); txv = 1'b1;
            end else begin
              activity_next = SUB_R1; byte_count_next = '0; tx = 8'hFF; txv = 1'b1;
            end
          end
          SUB_R1: begin
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(2)) begin
              tx = 8'hFF; txv = 1'b1;
            end else begin
              // act on the R1 response
              case (phase)
                PH_CMD0: begin
                  if (b == 8'h01) begin bready = 1'b1; bph = PH_CMD8; end
                  else begin
                    loop_count_next = loop_inc;
                    if (loop_inc >= lim) begin fin = 1'b1; fst = sdspi_pkg::ST_NO_CARD; end
                    else begin bcmd = 1'b1; bph = PH_CMD0; end
                  end
                end
                PH_CMD8: begin
                  if (b != 8'h01) begin
                    loop_count_next = '0; bready = 1'b1; bph = PH_CMD1;
                  end else begin
                    activity_next = SUB_R32; byte_count_next = '0;
                    response_word_next = '0; tx = 8'hFF; txv = 1'b1;
                  end
                end
                PH_CMD1, PH_ACMD41: begin
                  if (b == 8'h00) begin bready = 1'b1; bph = PH_CRCOFF; end
                  else begin
                    loop_count_next = loop_inc;
                    if (loop_inc >= lim) begin fin = 1'b1; fst = sdspi_pkg::ST_UNUSABLE; end
                    else begin
                      bready = 1'b1; bph = (phase == PH_CMD1) ? PH_CMD1 : PH_CMD55;
                    end
                  end
                end
                PH_OCR1: begin
                  if (b != 8'h01) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin
                    activity_next = SUB_R32; byte_count_next = '0;
                    response_word_next = '0; tx = 8'hFF; txv = 1'b1;
                  end
                end
                PH_CRCON: begin
                  if (b != 8'h01) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin loop_count_next = '0; bready = 1'b1; bph = PH_CMD55; end
                end
                PH_CMD55: begin bready = 1'b1; bph = PH_ACMD41; end
                PH_CRCOFF, PH_BLEN: begin
                  if (b != 8'h00) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin bready = 1'b1; bph = (phase == PH_CRCOFF) ? PH_BLEN : PH_OCR2; end
                end
                PH_OCR2: begin
                  if (b != 8'h00) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin
                    activity_next = SUB_R32; byte_count_next = '0;
                    response_word_next = '0; tx = 8'hFF; txv = 1'b1;
                  end
                end
                PH_RDCMD: begin
                  if (b != 8'h00) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin
                    phase_next = PH_RDTOK; activity_next = SUB_NONE;
                    retry_count_next = '0; tx = 8'hFF; txv = 1'b1;
                  end
                end
                PH_WRCMD: begin
                  if (b != 8'h00) begin fin = 1'b1; fst = sdspi_pkg::ST_R1_ERR; fr1 = b; end
                  else begin
                    phase_next = PH_WRDATA; activity_next = SUB_NONE;
                    byte_count_next = '0; tx = 8'hFE; txv = 1'b1;
                    o.want_write_byte = 1'b1;
                  end
                end
                default: begin fin = 1'b1; fst = sdspi_pkg::ST_OTHER; end
              endcase
            end
          end
          default: begin
            // 32-bit response collection
            response_word_next = rw_shift;
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(4)) begin
              tx = 8'hFF; txv = 1'b1;
            end else if (phase == PH_CMD8) begin
              if (rw_shift[7:0] != 8'hAA) begin fin = 1'b1; fst = sdspi_pkg::ST_ECHO; end
              else if (rw_shift[11:8] != 4'h1) begin
                fin = 1'b1; fst = sdspi_pkg::ST_VOLTAGE;
              end else begin bready = 1'b1; bph = PH_OCR1; end
            end else if (phase == PH_OCR1) begin
              if (rw_shift[23:15] != 9'h1FF) begin fin = 1'b1; fst = sdspi_pkg::ST_VOLTAGE; end
              else begin bready = 1'b1; bph = PH_CRCON; end
            end else begin
              capacity_status_next = rw_shift[31:30];
              initialized_next = 1'b1;
              fin = 1'b1; fst = sdspi_pkg::ST_OK;
            end
          end
        endcase
      end else begin
        case (phase)
          PH_CLOCK: begin
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(sdspi_pkg::INIT_CLOCK_BYTES)) begin
              tx = 8'hFF; txv = 1'b1;
            end else begin
              cs_on_next = 1'b1; loop_count_next = '0; bcmd = 1'b1; bph = PH_CMD0;
            end
          end
          PH_RDTOK: begin
            if (b == 8'hFE) begin
              phase_next = PH_RDDATA; byte_count_next = '0; tx = 8'hFF; txv = 1'b1;
            end else begin
              retry_count_next = retry_inc;
              if (retry_inc >= lim) begin fin = 1'b1; fst = sdspi_pkg::ST_NO_TOKEN; end
              else begin tx = 8'hFF; txv = 1'b1; end
            end
          end
          PH_RDDATA: begin
            o.read_byte = b; o.read_valid = 1'b1;
            byte_count_next = bc_inc;
            if (bc_inc >= BCW'(sdspi_pkg::BLOCK_BYTES)) begin
              phase_next = PH_RDCRC; byte_count_next = '0;
            end
            tx = 8'hFF; txv = 1'b1;
          end
          PH_RDCRC: begin
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(2)) begin tx = 8'hFF; txv = 1'b1; end
            else begin fin = 1'b1; fst = sdspi_pkg::ST_OK; end
          end
          PH_WRDATA: begin
            tx = q_req.write_byte; txv = 1'b1;
            byte_count_next = bc_inc;
            if (bc_inc < BCW'(sdspi_pkg::BLOCK_BYTES)) o.want_write_byte = 1'b1;
            else begin phase_next = PH_WRTAIL; byte_count_next = '0; end
          end
          PH_WRTAIL: begin
            if (byte_count < BCW'(3)) begin
              byte_count_next = bc_inc; tx = 8'hFF; txv = 1'b1;
            end else begin
              response_word_next = {29'd0, b[3:1]};
              phase_next = PH_WRREADY; activity_next = SUB_READY;
              retry_count_next = '0; tx = 8'hFF; txv = 1'b1;
            end
          end
          default: begin fin = 1'b1; fst = sdspi_pkg::ST_OTHER; end
        endcase
      end
    end

    // start of a command, with or without the ready poll
    if (bready || bcmd) begin
      phase_next = bph; byte_count_next = '0;
      if (bready) begin
        activity_next = SUB_READY; retry_count_next = '0; tx = 8'hFF;
      end else begin
        activity_next = SUB_CMD; tx = cmd_byte(bph, card_address_next, '0);
      end
      txv = 1'b1;
    end
    if (fin) begin
      o.done_res = 1'b1; o.status = fst; o.r1_value = fr1;
      tx = 8'd0; txv = 1'b0;
      phase_next = PH_IDLE; activity_next = SUB_NONE; cs_on_next = 1'b0;
    end
    o.tx_byte = tx; o.tx_valid = txv;
    o.chip_select_low = cs_on_next;
    o.fast_clock = initialized_next;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= 16'd100;
      phase <= PH_IDLE; activity <= SUB_NONE;
      retry_count <= '0; loop_count <= '0; byte_count <= '0;
      card_address <= '0; capacity_status <= '0; response_word <= '0;
      initialized <= 1'b0; cs_on <= 1'b0; out_full <= 1'b0;
    end else begin
      if (cfg_we) timeout_limit <= cfg_data;
      if (step) begin
        phase <= phase_next; activity <= activity_next;
        retry_count <= retry_count_next; loop_count <= loop_count_next;
        byte_count <= byte_count_next; card_address <= card_address_next;
        capacity_status <= capacity_status_next;
        response_word <= response_word_next;
        initialized <= initialized_next; cs_on <= cs_on_next;
      end
      if (step) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) out_reg <= o;
  end
endmodule

// ----- rtl/sdspi_checker.sv -----
`timescale 1ns / 1ps
// port-level checks
module sdspi_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       tx_valid,
  input logic [7:0] tx_byte,
  input logic       done_res,
  input logic [3:0] status,
  input logic       chip_select_low,
  input logic       read_valid
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(status)))
    else $error("result changed while stalled");
  // an ending result transfers nothing and releases chip select
  a_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> (!tx_valid && !chip_select_low))
    else $error("end result with transfer or select");
  // status is zero unless ending or refused
  a_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && !done_res && status != sdspi_pkg::ST_BUSY) |-> (status == sdspi_pkg::ST_OK))
    else $error("status without end");
  // sector data only with a transfer
  a_read: assert property (@(posedge clk) disable iff (rst)
    (!empty && read_valid) |-> (tx_valid && chip_select_low))
    else $error("read data without transfer");
endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .tx_valid(tx_valid),
  .tx_byte(tx_byte), .done_res(done_res), .status(status),
  .chip_select_low(chip_select_low), .read_valid(read_valid)
);

// ----- verif/sd_card_spi_host_sequencer_test.sv -----
`timescale 1ns / 1ps
module sd_card_spi_host_sequencer_test;
  localparam int CYCLE_LIMIT = 2000000;

  typedef enum int {
    PH_IDLE, PH_CLOCK, PH_CMD0, PH_CMD8, PH_CMD1, PH_OCR1, PH_CRCON, PH_CMD55,
    PH_ACMD41, PH_CRCOFF, PH_BLEN, PH_OCR2, PH_RDCMD, PH_RDTOK, PH_RDDATA,
    PH_RDCRC, PH_WRCMD, PH_WRDATA, PH_WRTAIL, PH_WRREADY
  } seq_phase_t;

  typedef enum int {ACT_NONE, ACT_READY, ACT_CMD, ACT_R1, ACT_R32} seq_act_t;

  // model of the sequencer plus the queue of results it predicts
  class scoreboard_t;
    seq_phase_t ph;
    seq_act_t act;
    bit [15:0] limit;
    int unsigned retries, bcount, loops;
    bit [31:0] caddr, resp;
    bit [1:0] cap;
    bit init_done, cs;
    sdspi_pkg::res_t o;
    sdspi_pkg::res_t pending[$];
    int errors;

    function new();
      ph = PH_IDLE; act = ACT_NONE; limit = 16'd100;
      retries = 0; bcount = 0; loops = 0; caddr = '0; resp = '0;
      cap = '0; init_done = 0; cs = 0; errors = 0;
    endfunction

    function bit idle();
      return ph == PH_IDLE;
    endfunction

    function int unsigned lim_eff();
      return (limit == 0) ? 1 : limit;
    endfunction

    function void emit(bit [7:0] b);
      o.tx_byte = b;
      o.tx_valid = 1'b1;
    endfunction

    function bit [7:0] cmd_byte(int unsigned k);
      bit [5:0] idx;
      bit [31:0] arg;
      bit [6:0] crc;
      idx = 0; arg = 0; crc = 7'h7F;
      case (ph)
        PH_CMD0: begin idx = 0; crc = 7'h4A; end
        PH_CMD8: begin idx = 8; arg = 32'h0000_01AA; crc = 7'h43; end
        PH_CMD1: begin idx = 1; crc = 7'h7C; end
        PH_OCR1, PH_OCR2: begin idx = 58; crc = 7'h7E; end
        PH_CRCON: begin idx = 59; arg = 1; crc = 7'h41; end
        PH_CMD55: begin idx = 55; crc = 7'h32; end
        PH_ACMD41: begin idx = 41; arg = 32'h4000_0000; crc = 7'h3B; end
        PH_CRCOFF: begin idx = 59; crc = 7'h48; end
        PH_BLEN: begin idx = 16; arg = 32'h0000_0200; crc = 7'h0A; end
        PH_RDCMD: begin idx = 17; arg = caddr; end
        PH_WRCMD: begin idx = 24; arg = caddr; end
        default: ;
      endcase
      case (k)
        0: return 8'h40 | idx;
        1: return arg[31:24];
        2: return arg[23:16];
        3: return arg[15:8];
        4: return arg[7:0];
        default: return {crc, 1'b1};
      endcase
    endfunction

    function void finish_op(bit [3:0] st, bit [7:0] r1);
      o.done_res = 1'b1;
      o.status = st;
      o.r1_value = r1;
      o.tx_valid = 1'b0;
      o.tx_byte = '0;
      ph = PH_IDLE;
      act = ACT_NONE;
      cs = 0;
    endfunction

    function void begin_cmd(seq_phase_t p, bit ready_first);
      ph = p;
      bcount = 0;
      if (ready_first) begin
        act = ACT_READY;
        retries = 0;
        emit(8'hFF);
      end else begin
        act = ACT_CMD;
        emit(cmd_byte(0));
      end
    endfunction

    function void start_word();
      act = ACT_R32;
      bcount = 0;
      resp = '0;
      emit(8'hFF);
    endfunction

    function void retry_loop(seq_phase_t again, bit [3:0] fail_st);
      loops++;
      if (loops >= lim_eff()) finish_op(fail_st, 0);
      else begin_cmd(again, 1);
    endfunction

    // decision on the R1 byte of each command
    function void after_r1(bit [7:0] r1);
      case (ph)
        PH_CMD0:
          if (r1 == 8'h01) begin_cmd(PH_CMD8, 1);
          else begin
            loops++;
            if (loops >= lim_eff()) finish_op(sdspi_pkg::ST_NO_CARD, 0);
            else begin_cmd(PH_CMD0, 0);
          end
        PH_CMD8:
          if (r1 != 8'h01) begin loops = 0; begin_cmd(PH_CMD1, 1); end
          else start_word();
        PH_CMD1:
          if (r1 == 0) begin_cmd(PH_CRCOFF, 1);
          else retry_loop(PH_CMD1, sdspi_pkg::ST_UNUSABLE);
        PH_OCR1:
          if (r1 != 8'h01) finish_op(sdspi_pkg::ST_R1_ERR, r1); else start_word();
        PH_CRCON:
          if (r1 != 8'h01) finish_op(sdspi_pkg::ST_R1_ERR, r1);
          else begin loops = 0; begin_cmd(PH_CMD55, 1); end
        PH_CMD55: begin_cmd(PH_ACMD41, 1);
        PH_ACMD41:
          if (r1 == 0) begin_cmd(PH_CRCOFF, 1);
          else retry_loop(PH_CMD55, sdspi_pkg::ST_UNUSABLE);
        PH_CRCOFF:
          if (r1 != 0) finish_op(sdspi_pkg::ST_R1_ERR, r1); else begin_cmd(PH_BLEN, 1);
        PH_BLEN:
          if (r1 != 0) finish_op(sdspi_pkg::ST_R1_ERR, r1); else begin_cmd(PH_OCR2, 1);
        PH_OCR2:
          if (r1 != 0) finish_op(sdspi_pkg::ST_R1_ERR, r1); else start_word();
        PH_RDCMD:
          if (r1 != 0) finish_op(sdspi_pkg::ST_R1_ERR, r1);
          else begin ph = PH_RDTOK; act = ACT_NONE; retries = 0; emit(8'hFF); end
        PH_WRCMD:
          if (r1 != 0) finish_op(sdspi_pkg::ST_R1_ERR, r1);
          else begin
            ph = PH_WRDATA; act = ACT_NONE; bcount = 0;
            emit(8'hFE); o.want_write_byte = 1'b1;
          end
        default: finish_op(sdspi_pkg::ST_OTHER, 0);
      endcase
    endfunction

    function void after_word();
      if (ph == PH_CMD8) begin
        if (resp[7:0] != 8'hAA) finish_op(sdspi_pkg::ST_ECHO, 0);
        else if (resp[11:8] != 4'h1) finish_op(sdspi_pkg::ST_VOLTAGE, 0);
        else begin_cmd(PH_OCR1, 1);
      end else if (ph == PH_OCR1) begin
        if (resp[23:15] != 9'h1FF) finish_op(sdspi_pkg::ST_VOLTAGE, 0);
        else begin_cmd(PH_CRCON, 1);
      end else begin
        cap = resp[31:30];
        init_done = 1;
        finish_op(sdspi_pkg::ST_OK, 0);
      end
    endfunction

    // command level: ready poll, command bytes, R1, 32-bit response
    function void run_sub(bit [7:0] b);
      bit [2:0] code;
      case (act)
        ACT_READY:
          if (b == 8'hFF) begin
            if (ph == PH_WRREADY) begin
              code = resp[2:0];
              case (code)
                3'd2: finish_op(sdspi_pkg::ST_OK, 0);
                3'd5: finish_op(sdspi_pkg::ST_CRC_REJ, 0);
                3'd6: finish_op(sdspi_pkg::ST_WR_REJ, 0);
                default: finish_op(sdspi_pkg::ST_OTHER, 0);
              endcase
            end else begin
              act = ACT_CMD; bcount = 0; emit(cmd_byte(0));
            end
          end else begin
            retries++;
            if (retries >= lim_eff()) finish_op(sdspi_pkg::ST_NOT_READY, 0);
            else emit(8'hFF);
          end
        ACT_CMD: begin
          bcount++;
          if (bcount < 6) emit(cmd_byte(bcount));
          else begin act = ACT_R1; bcount = 0; emit(8'hFF); end
        end
        ACT_R1: begin
          bcount++;
          if (bcount < 2) emit(8'hFF); else after_r1(b);
        end
        default: begin
          resp = {resp[23:0], b};
          bcount++;
          if (bcount < 4) emit(8'hFF); else after_word();
        end
      endcase
    endfunction

    // data level: init clocks, read token and data, write data and tail
    function void run_phase(bit [7:0] b, bit [7:0] wb);
      case (ph)
        PH_CLOCK: begin
          bcount++;
          if (bcount < sdspi_pkg::INIT_CLOCK_BYTES) emit(8'hFF);
          else begin cs = 1; loops = 0; begin_cmd(PH_CMD0, 0); end
        end
        PH_RDTOK:
          if (b == 8'hFE) begin ph = PH_RDDATA; bcount = 0; emit(8'hFF); end
          else begin
            retries++;
            if (retries >= lim_eff()) finish_op(sdspi_pkg::ST_NO_TOKEN, 0);
            else emit(8'hFF);
          end
        PH_RDDATA: begin
          o.read_byte = b;
          o.read_valid = 1'b1;
          bcount++;
          if (bcount >= sdspi_pkg::BLOCK_BYTES) begin ph = PH_RDCRC; bcount = 0; end
          emit(8'hFF);
        end
        PH_RDCRC: begin
          bcount++;
          if (bcount < 2) emit(8'hFF); else finish_op(sdspi_pkg::ST_OK, 0);
        end
        PH_WRDATA: begin
          emit(wb);
          bcount++;
          if (bcount < sdspi_pkg::BLOCK_BYTES) o.want_write_byte = 1'b1;
          else begin ph = PH_WRTAIL; bcount = 0; end
        end
        PH_WRTAIL:
          if (bcount < 3) begin bcount++; emit(8'hFF); end
          else begin
            resp = {29'd0, b[3:1]};
            ph = PH_WRREADY; act = ACT_READY; retries = 0;
            emit(8'hFF);
          end
        default: finish_op(sdspi_pkg::ST_OTHER, 0);
      endcase
    endfunction

    function void note_request(sdspi_pkg::req_t r);
      bit [31:0] addr;
      o = '0;
      addr = r.block_address;
      if (r.req_type != sdspi_pkg::REQ_XCHG) begin
        if (ph != PH_IDLE) o.status = sdspi_pkg::ST_BUSY;
        else if (r.req_type == sdspi_pkg::REQ_INIT) begin
          init_done = 0; cs = 0; ph = PH_CLOCK; act = ACT_NONE; bcount = 0;
          emit(8'hFF);
        end else begin
          if (cap == 2'd2) addr = addr << 9;
          caddr = addr;
          cs = 1;
          begin_cmd(r.req_type == sdspi_pkg::REQ_READ ? PH_RDCMD : PH_WRCMD, 1);
        end
      end else if (ph != PH_IDLE) begin
        if (act != ACT_NONE) run_sub(r.card_byte);
        else run_phase(r.card_byte, r.write_byte);
      end
      o.chip_select_low = cs;
      o.fast_clock = init_done;
      pending.push_back(o);
    endfunction

    function void field_check(string name, int unsigned exp, int unsigned act_v);
      if (exp != act_v) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act_v);
        errors++;
      end
    endfunction

    function void check_result(sdspi_pkg::res_t r);
      sdspi_pkg::res_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with no request outstanding, got %h", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_check("tx_byte", e.tx_byte, r.tx_byte);
      field_check("tx_valid", e.tx_valid, r.tx_valid);
      field_check("chip_select_low", e.chip_select_low, r.chip_select_low);
      field_check("fast_clock", e.fast_clock, r.fast_clock);
      field_check("read_byte", e.read_byte, r.read_byte);
      field_check("read_valid", e.read_valid, r.read_valid);
      field_check("want_write_byte", e.want_write_byte, r.want_write_byte);
      field_check("done_res", e.done_res, r.done_res);
      field_check("status", e.status, r.status);
      field_check("r1_value", e.r1_value, r.r1_value);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic full, empty;
  logic pop = 0;
  logic [1:0] req_type = sdspi_pkg::REQ_XCHG;
  logic [31:0] block_address = '0;
  logic [7:0] write_byte = '0;
  logic [7:0] card_byte = '0;
  logic [7:0] tx_byte, read_byte, r1_value;
  logic tx_valid, chip_select_low, fast_clock, read_valid, want_write_byte, done_res;
  logic [3:0] status;
  logic cfg_we = 0;
  logic [15:0] cfg_data = '0;

  scoreboard_t sb = new();
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int cycles = 0;

  sd_card_spi_host_sequencer dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .block_address(block_address),
    .write_byte(write_byte), .card_byte(card_byte),
    .empty(empty), .pop(pop),
    .tx_byte(tx_byte), .tx_valid(tx_valid), .chip_select_low(chip_select_low),
    .fast_clock(fast_clock), .read_byte(read_byte), .read_valid(read_valid),
    .want_write_byte(want_write_byte), .done_res(done_res), .status(status),
    .r1_value(r1_value), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sd_card_spi_host_sequencer verification failed");
      $finish;
    end
  end

  // result side: check each popped result, then pick the next pop
  always @(posedge clk) begin
    sdspi_pkg::res_t r;
    if (!rst && pop && !empty) begin
      r.tx_byte = tx_byte; r.tx_valid = tx_valid;
      r.chip_select_low = chip_select_low; r.fast_clock = fast_clock;
      r.read_byte = read_byte; r.read_valid = read_valid;
      r.want_write_byte = want_write_byte; r.done_res = done_res;
      r.status = status; r.r1_value = r1_value;
      sb.check_result(r);
    end
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // drive one request and wait until it is taken
  task automatic send(logic [1:0] rt, logic [31:0] addr, logic [7:0] wb, logic [7:0] cb);
    sdspi_pkg::req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req_type <= rt;
    block_address <= addr;
    write_byte <= wb;
    card_byte <= cb;
    r.req_type = rt; r.block_address = addr; r.write_byte = wb; r.card_byte = cb;
    do @(posedge clk); while (full);
    sb.note_request(r);
  endtask

  // what a well-behaved card would answer, with some noise
  function automatic logic [7:0] card_reply();
    logic [7:0] rnd;
    int p;
    rnd = 8'($urandom);
    p = $urandom_range(99);
    if ($urandom_range(99) < 6) return rnd;
    case (sb.act)
      ACT_READY: return (p < 75) ? 8'hFF : rnd;
      ACT_CMD: return rnd;
      ACT_R1: begin
        if (sb.bcount == 0) return rnd;
        case (sb.ph)
          PH_CMD0: return (p < 80) ? 8'h01 : rnd;
          PH_CMD8: return (p < 70) ? 8'h01 : 8'h05;
          PH_CMD1, PH_ACMD41: return (p < 50) ? 8'h00 : 8'h01;
          PH_OCR1, PH_CRCON, PH_CMD55: return 8'h01;
          default: return 8'h00;
        endcase
      end
      ACT_R32:
        case (sb.ph)
          PH_CMD8: case (sb.bcount)
            2: return 8'h01;
            3: return 8'hAA;
            default: return 8'h00;
          endcase
          PH_OCR1: case (sb.bcount)
            1: return 8'hFF;
            2: return 8'h80 | rnd;
            default: return rnd;
          endcase
          default: return rnd;
        endcase
      default:
        case (sb.ph)
          PH_RDTOK: return (p < 50) ? 8'hFE : 8'hFF;
          PH_WRTAIL: begin
            if (sb.bcount != 3) return rnd;
            case (p % 4)
              0: return {rnd[7:4], 3'd2, 1'b1};
              1: return {rnd[7:4], 3'd5, 1'b1};
              2: return {rnd[7:4], 3'd6, 1'b1};
              default: return rnd;
            endcase
          end
          default: return rnd;
        endcase
    endcase
  endfunction

  // bring the block back to idle with plausible card answers
  task automatic drain_to_idle();
    while (!sb.idle()) send(sdspi_pkg::REQ_XCHG, $urandom, 8'($urandom), card_reply());
  endtask

  // write timeout_limit once every result has arrived
  task automatic set_limit(logic [15:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic random_request();
    int p;
    p = $urandom_range(99);
    if (sb.idle()) begin
      if (p < 10)
        send(sdspi_pkg::REQ_XCHG, $urandom, 8'($urandom), 8'($urandom));
      else if (p < 45)
        send(sdspi_pkg::REQ_INIT, $urandom, 8'($urandom), 8'($urandom));
      else if (p < 72)
        send(sdspi_pkg::REQ_READ, $urandom, 8'($urandom), 8'($urandom));
      else
        send(sdspi_pkg::REQ_WRITE, $urandom, 8'($urandom), 8'($urandom));
    end else if (p < 3) begin
      send(2'($urandom_range(3, 1)), $urandom, 8'($urandom), 8'($urandom));
    end else begin
      send(sdspi_pkg::REQ_XCHG, $urandom, 8'($urandom), card_reply());
    end
  endtask

  initial begin
    logic [15:0] limits[6];
    int idle_mode[4][2];
    limits = '{16'd0, 16'd100, 16'd3, 16'hFFFF, 16'd1, 16'd20};
    idle_mode = '{'{0, 0}, '{60, 0}, '{0, 60}, '{25, 25}};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: exchange while idle, extreme address, busy refusal, timeouts
    send(sdspi_pkg::REQ_XCHG, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    set_limit(16'd1);
    send(sdspi_pkg::REQ_READ, 32'hFFFF_FFFF, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_INIT, 32'h0, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_WRITE, 32'h0, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_XCHG, 32'h0, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_READ, 32'h0, 8'hFF, 8'h00);
    send(sdspi_pkg::REQ_XCHG, 32'h0, 8'h00, 8'hFF);
    repeat (7) send(sdspi_pkg::REQ_XCHG, 32'h0, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_XCHG, 32'h0, 8'h00, 8'h05);
    send(sdspi_pkg::REQ_WRITE, 32'h8000_0001, 8'h00, 8'h00);
    send(sdspi_pkg::REQ_XCHG, 32'h0, 8'h00, 8'hFE);
    send(sdspi_pkg::REQ_INIT, 32'h0, 8'h00, 8'h00);
    drain_to_idle();

    // random phases over idling patterns and timeout settings
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      set_limit(limits[ph_i]);
      send_idle_pct = idle_mode[ph_i % 4][0];
      pop_stall_pct = idle_mode[ph_i % 4][1];
      repeat (100) random_request();
      drain_to_idle();
    end

    push <= 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("sd_card_spi_host_sequencer verification clean");
    else
      $display("sd_card_spi_host_sequencer verification failed");
    $finish;
  end
endmodule
